[hw/rtl/message_packet_fifo_unit_macros.svh]
// ----------------------------------------------------------------------------
// message_packet_fifo_unit_macros.svh
// Assertion macros for the message packet FIFO. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_PACKET_FIFO_UNIT_MACROS_SVH
`define MESSAGE_PACKET_FIFO_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define MPF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("message packet FIFO assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define MPF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("message packet FIFO assertion failed");
`else
`define MPF_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define MPF_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

[hw/rtl/mpf_pkg.sv]
// ----------------------------------------------------------------------------
// mpf_pkg
// Sizes, codes, result type and byte helpers shared by the message packet
// FIFO files. Store and slot depths must be powers of two.
// ----------------------------------------------------------------------------
`default_nettype none

package mpf_pkg;

  // Store geometry.
  localparam int DATA_WORDS        = 1024;
  localparam int MESSAGE_SLOTS     = 16;
  localparam int MAX_MESSAGE_BYTES = 512;

  localparam int WORD_AW    = $clog2(DATA_WORDS);
  localparam int BANK_WORDS = DATA_WORDS / 2;
  localparam int BANK_AW    = $clog2(BANK_WORDS);
  localparam int SLOT_AW    = $clog2(MESSAGE_SLOTS);
  localparam int CNT_W      = $clog2(MESSAGE_SLOTS + 1);
  localparam int LEN_W      = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int NEWLEN_W   = $clog2(MAX_MESSAGE_BYTES + 9);
  localparam int MAX_WORDS  = (MAX_MESSAGE_BYTES + 7) / 8;
  localparam int WCNT_W     = $clog2(MAX_WORDS + 1);
  localparam int HELD_W     = WORD_AW + 1;
  localparam int SUM_W      = WORD_AW + 2;
  localparam int TOTAL_W    = $clog2(MESSAGE_SLOTS * MAX_MESSAGE_BYTES + 1);

  // Field widths of the channels.
  localparam int ACTION_W = 2;
  localparam int DATA_W   = 64;
  localparam int BCOUNT_W = 4;
  localparam int BUFSZ_W  = 16;
  localparam int STATUS_W = 2;
  localparam int MLEN_W   = 10;
  localparam int MQ_W     = 5;
  localparam int BQ_W     = 14;

  // Actions. Any other code behaves as a peek.
  localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_TOOLONG = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

  // One result transaction.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   out_word;
    logic [BCOUNT_W-1:0] out_count;
    logic                out_last;
    logic [MLEN_W-1:0]   message_length;
    logic [MQ_W-1:0]     messages_queued;
    logic [BQ_W-1:0]     bytes_queued;
  } mpf_result_t;

  // Keeps the lowest n bytes of a word and zeroes the rest; n of eight or
  // more keeps the whole word.
  function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] w,
                                                  input logic [BCOUNT_W-1:0] n);
    logic [DATA_W-1:0] res;
    res = '0;
    for (int b = 0; b < 8; b++) begin
      if (BCOUNT_W'(b) < n) begin
        res[8*b +: 8] = w[8*b +: 8];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mpf_if.sv]
// ----------------------------------------------------------------------------
// mpf_if
// Valid/ready channels of the message packet FIFO: the request channel
// and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: one push word, pop or peek per transaction.
interface mpf_in_if;
  logic                            valid;
  logic                            ready;
  logic [mpf_pkg::ACTION_W-1:0]    action;
  logic [mpf_pkg::DATA_W-1:0]      data_word;
  logic [mpf_pkg::BCOUNT_W-1:0]    byte_count;
  logic                            last_word;
  logic [mpf_pkg::BUFSZ_W-1:0]     buffer_size;

  modport source (output valid, action, data_word, byte_count, last_word, buffer_size,
                  input ready);
  modport sink (input valid, action, data_word, byte_count, last_word, buffer_size,
                output ready);
endinterface

// Result channel: one status or one popped word per transaction.
interface mpf_out_if;
  logic                            valid;
  logic                            ready;
  logic [mpf_pkg::STATUS_W-1:0]    status;
  logic [mpf_pkg::DATA_W-1:0]      out_word;
  logic [mpf_pkg::BCOUNT_W-1:0]    out_count;
  logic                            out_last;
  logic [mpf_pkg::MLEN_W-1:0]      message_length;
  logic [mpf_pkg::MQ_W-1:0]        messages_queued;
  logic [mpf_pkg::BQ_W-1:0]        bytes_queued;

  modport source (output valid, status, out_word, out_count, out_last, message_length,
                  messages_queued, bytes_queued, input ready);
  modport sink (input valid, status, out_word, out_count, out_last, message_length,
                messages_queued, bytes_queued, output ready);
endinterface

`default_nettype wire

[hw/rtl/mpf_ram.sv]
// ----------------------------------------------------------------------------
// mpf_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module mpf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire              clk,
  input  wire              we,
  input  wire  [AW-1:0]    waddr,
  input  wire  [WIDTH-1:0] wdata,
  input  wire              re,
  input  wire  [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/mpf_pack.sv]
// ----------------------------------------------------------------------------
// mpf_pack
// Byte packer for pushed words: masks the incoming word to its byte count
// and aligns it behind the bytes already held in the open store word.
// ----------------------------------------------------------------------------
`default_nettype none

module mpf_pack (
  input  wire  [mpf_pkg::DATA_W-1:0]   data_word,
  input  wire  [mpf_pkg::BCOUNT_W-1:0] byte_count,
  input  wire  [mpf_pkg::DATA_W-1:0]   tail_word,
  input  wire  [2:0]                   offset,
  output logic [mpf_pkg::BCOUNT_W-1:0] n_bytes,
  output logic [mpf_pkg::DATA_W-1:0]   lo_word,
  output logic [mpf_pkg::DATA_W-1:0]   spill_word
);

  import mpf_pkg::*;

  logic [DATA_W-1:0]   data_masked;
  logic [2*DATA_W-1:0] shifted;

  // Byte counts above eight count as eight.
  assign n_bytes = (byte_count > BCOUNT_W'(8)) ? BCOUNT_W'(8) : byte_count;

  // Align the new bytes behind the open word; what passes the word end spills.
  always_comb begin
    data_masked = keep_bytes(data_word, n_bytes);
    shifted     = {{DATA_W{1'b0}}, data_masked} << {offset, 3'b000};
    lo_word     = shifted[DATA_W-1:0] | ((offset != 3'd0) ? tail_word : '0);
    spill_word  = shifted[2*DATA_W-1:DATA_W];
  end

endmodule

`default_nettype wire

[hw/rtl/message_packet_fifo_unit.sv]
// ----------------------------------------------------------------------------
// message_packet_fifo_unit
// A FIFO of whole variable-length messages with a length descriptor per
// message. Push, peek and rejected requests give one result each; the
// request port is ready whenever no pop burst or descriptor refresh is
// running and the result register is free or being emptied. A pop that
// frees a message of L bytes gives ceil(L/8) results, one per cycle while
// the result channel is ready, each read through the registered read port
// of the word store; a pop of a zero-length message gives one result at once.
// After a pop that frees a zero-length message the port stalls while the
// next descriptor is read from the length memory; for a longer message
// that read is hidden under the burst. The word store is two banks of even
// and odd words so that a push whose bytes cross a word boundary writes
// both words in the same cycle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "message_packet_fifo_unit_macros.svh"

module message_packet_fifo_unit (
  input  wire        clk,
  input  wire        rst_n,
  mpf_in_if.sink     in_ch,
  mpf_out_if.source  out_ch
);

  import mpf_pkg::*;

  typedef enum logic {ST_IDLE, ST_POP} state_t;

  // Control registers.
  state_t              state_r, state_nxt;
  logic [WORD_AW-1:0]  wwp_r, wwp_nxt;
  logic [WORD_AW-1:0]  wrp_r, wrp_nxt;
  logic [SLOT_AW-1:0]  swp_r, swp_nxt;
  logic [SLOT_AW-1:0]  srp_r, srp_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0]  bytes_r, bytes_nxt;
  logic [LEN_W-1:0]    plen_r, plen_nxt;
  logic [HELD_W-1:0]   held_r, held_nxt;
  logic                disc_r, disc_nxt;
  logic [LEN_W-1:0]    head_len_r, head_len_nxt;
  logic                head_load_r, head_load_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WCNT_W-1:0]   iss_left_r, iss_left_nxt;
  logic [WORD_AW-1:0]  rd_idx_r, rd_idx_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic                rd_bank_r, rd_bank_nxt;

  // Payload registers.
  mpf_result_t         out_q_r, out_q_nxt;
  logic [DATA_W-1:0]   tail_r;
  logic [LEN_W-1:0]    burst_len_r;

  // Handshake.
  logic in_ready;
  logic in_acc;
  logic ld_out;

  // Push datapath.
  logic [BCOUNT_W-1:0] n_bytes;
  logic [DATA_W-1:0]   lo_word;
  logic [DATA_W-1:0]   spill_word;
  logic [2:0]          offset;
  logic [NEWLEN_W-1:0] newlen;
  logic [NEWLEN_W-1:0] need;
  logic [4:0]          fill_sum;
  logic                push_full;
  logic [WORD_AW-1:0]  widx;
  logic [WORD_AW-1:0]  widx_p1;
  logic                lo_we;
  logic                sp_we;
  logic                tail_we;
  logic [LEN_W-1:0]    oldest_len;

  // Pop datapath.
  logic [LEN_W:0]      hl_round;
  logic [WCNT_W-1:0]   pop_words;
  logic                rd_issue;
  logic                burst_we;
  logic [DATA_W-1:0]   rd_word;
  logic [BCOUNT_W-1:0] burst_cnt;

  // Memory ports.
  logic                slot_we;
  logic                slot_re;
  logic [LEN_W-1:0]    slot_rdata;
  logic                b0_we, b1_we;
  logic [BANK_AW-1:0]  b0_waddr, b1_waddr;
  logic [DATA_W-1:0]   b0_wdata, b1_wdata;
  logic                b0_re, b1_re;
  logic [DATA_W-1:0]   b0_rdata, b1_rdata;

  // Request port is open only between bursts and descriptor refreshes.
  assign in_ready     = (state_r == ST_IDLE) && !head_load_r && (!out_valid_r || out_ch.ready);
  assign in_acc       = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;

  // Byte packing of a push word.
  assign offset = plen_r[2:0];

  mpf_pack u_pack (
    .data_word  (in_ch.data_word),
    .byte_count (in_ch.byte_count),
    .tail_word  (tail_r),
    .offset     (offset),
    .n_bytes    (n_bytes),
    .lo_word    (lo_word),
    .spill_word (spill_word)
  );

  // Push sizing and the three full conditions.
  always_comb begin
    newlen    = NEWLEN_W'(plen_r) + NEWLEN_W'(n_bytes);
    need      = (newlen + NEWLEN_W'(7)) >> 3;
    fill_sum  = {2'b00, offset} + {1'b0, n_bytes};
    push_full = (newlen > NEWLEN_W'(MAX_MESSAGE_BYTES)) ||
                ((SUM_W'(held_r) + SUM_W'(need)) > SUM_W'(DATA_WORDS)) ||
                (in_ch.last_word && (cnt_r >= CNT_W'(MESSAGE_SLOTS)));
    widx      = wwp_r + WORD_AW'(plen_r >> 3);
    widx_p1   = widx + WORD_AW'(1);
    oldest_len = (cnt_r != '0) ? head_len_r : '0;
  end

  // Pop sizing.
  always_comb begin
    hl_round  = {1'b0, head_len_r} + (LEN_W+1)'(7);
    pop_words = WCNT_W'(hl_round >> 3);
  end

  // Burst word selection and byte count.
  assign rd_word   = rd_bank_r ? b1_rdata : b0_rdata;
  assign burst_cnt = (rem_r >= LEN_W'(8)) ? BCOUNT_W'(8) : BCOUNT_W'(rem_r);

  // Next-state logic for requests and pop bursts.
  always_comb begin
    state_nxt     = state_r;
    wwp_nxt       = wwp_r;
    wrp_nxt       = wrp_r;
    swp_nxt       = swp_r;
    srp_nxt       = srp_r;
    cnt_nxt       = cnt_r;
    bytes_nxt     = bytes_r;
    plen_nxt      = plen_r;
    held_nxt      = held_r;
    disc_nxt      = disc_r;
    head_len_nxt  = head_len_r;
    head_load_nxt = 1'b0;
    iss_left_nxt  = iss_left_r;
    rd_idx_nxt    = rd_idx_r;
    rem_nxt       = rem_r;
    rd_pend_nxt   = rd_pend_r;
    rd_bank_nxt   = rd_bank_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ld_out        = 1'b0;
    lo_we         = 1'b0;
    sp_we         = 1'b0;
    tail_we       = 1'b0;
    slot_we       = 1'b0;
    slot_re       = 1'b0;
    rd_issue      = 1'b0;
    burst_we      = 1'b0;
    out_q_nxt     = '0;
    out_q_nxt.out_last = 1'b1;

    // Descriptor of the new oldest message arrives from the length memory in the cycle after a pop.
    if (head_load_r) begin
      head_len_nxt = slot_rdata;
    end

    if (in_acc) begin
      case (in_ch.action)
        ACT_PUSH: begin
          ld_out = 1'b1;
          out_q_nxt.message_length = MLEN_W'(oldest_len);
          if (disc_r) begin
            // Rest of a dropped message.
            out_q_nxt.status = STAT_FULL;
            if (in_ch.last_word) begin
              disc_nxt = 1'b0;
            end
          end else if (push_full) begin
            out_q_nxt.status = STAT_FULL;
            plen_nxt = '0;
            if (!in_ch.last_word) begin
              disc_nxt = 1'b1;
            end
          end else begin
            out_q_nxt.status = STAT_OK;
            lo_we    = (n_bytes != '0);
            sp_we    = (offset != 3'd0) && (fill_sum > 5'd8);
            tail_we  = (n_bytes != '0);
            plen_nxt = LEN_W'(newlen);
            if (in_ch.last_word) begin
              // Commit the message and its descriptor.
              slot_we   = 1'b1;
              swp_nxt   = swp_r + SLOT_AW'(1);
              cnt_nxt   = cnt_r + CNT_W'(1);
              bytes_nxt = bytes_r + TOTAL_W'(newlen);
              held_nxt  = held_r + HELD_W'(need);
              wwp_nxt   = wwp_r + WORD_AW'(need);
              plen_nxt  = '0;
              if (cnt_r == '0) begin
                head_len_nxt = LEN_W'(newlen);
                out_q_nxt.message_length = MLEN_W'(newlen);
              end
            end
          end
        end
        ACT_POP: begin
          if (cnt_r == '0) begin
            ld_out = 1'b1;
            out_q_nxt.status = STAT_EMPTY;
          end else if (in_ch.buffer_size < BUFSZ_W'(head_len_r)) begin
            ld_out = 1'b1;
            out_q_nxt.status = STAT_TOOLONG;
            out_q_nxt.message_length = MLEN_W'(head_len_r);
          end else begin
            // Free the message and fetch the next descriptor.
            srp_nxt       = srp_r + SLOT_AW'(1);
            cnt_nxt       = cnt_r - CNT_W'(1);
            bytes_nxt     = bytes_r - TOTAL_W'(head_len_r);
            held_nxt      = held_r - HELD_W'(pop_words);
            wrp_nxt       = wrp_r + WORD_AW'(pop_words);
            slot_re       = 1'b1;
            head_load_nxt = 1'b1;
            if (pop_words == '0) begin
              ld_out = 1'b1;
              out_q_nxt.status = STAT_OK;
              out_q_nxt.message_length = MLEN_W'(head_len_r);
            end else begin
              state_nxt    = ST_POP;
              burst_we     = 1'b1;
              iss_left_nxt = pop_words;
              rd_idx_nxt   = wrp_r;
              rem_nxt      = head_len_r;
              rd_pend_nxt  = 1'b0;
            end
          end
        end
        default: begin
          // Peek and unused codes.
          ld_out = 1'b1;
          if (cnt_r == '0) begin
            out_q_nxt.status = STAT_EMPTY;
          end else begin
            out_q_nxt.status = STAT_OK;
            out_q_nxt.message_length = MLEN_W'(head_len_r);
          end
        end
      endcase
    end

    // Pop burst: one read in flight, drained into the result register.
    if (state_r == ST_POP) begin
      if (rd_pend_r && (!out_valid_r || out_ch.ready)) begin
        ld_out = 1'b1;
        out_q_nxt.status         = STAT_OK;
        out_q_nxt.out_word       = keep_bytes(rd_word, burst_cnt);
        out_q_nxt.out_count      = burst_cnt;
        out_q_nxt.out_last       = (rem_r <= LEN_W'(8));
        out_q_nxt.message_length = MLEN_W'(burst_len_r);
        rem_nxt     = rem_r - LEN_W'(burst_cnt);
        rd_pend_nxt = 1'b0;
        if (rem_r <= LEN_W'(8)) begin
          state_nxt = ST_IDLE;
        end
      end
      if ((iss_left_r != '0) && (!rd_pend_r || ld_out)) begin
        rd_issue     = 1'b1;
        rd_pend_nxt  = 1'b1;
        rd_bank_nxt  = rd_idx_r[0];
        rd_idx_nxt   = rd_idx_r + WORD_AW'(1);
        iss_left_nxt = iss_left_r - WCNT_W'(1);
      end
    end

    out_q_nxt.messages_queued = MQ_W'(cnt_nxt);
    out_q_nxt.bytes_queued    = BQ_W'(bytes_nxt);
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // State machine and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wwp_r       <= '0;
      wrp_r       <= '0;
      swp_r       <= '0;
      srp_r       <= '0;
      cnt_r       <= '0;
      bytes_r     <= '0;
      plen_r      <= '0;
      held_r      <= '0;
      disc_r      <= 1'b0;
      head_len_r  <= '0;
      head_load_r <= 1'b0;
      out_valid_r <= 1'b0;
      iss_left_r  <= '0;
      rd_idx_r    <= '0;
      rem_r       <= '0;
      rd_pend_r   <= 1'b0;
      rd_bank_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wwp_r       <= wwp_nxt;
      wrp_r       <= wrp_nxt;
      swp_r       <= swp_nxt;
      srp_r       <= srp_nxt;
      cnt_r       <= cnt_nxt;
      bytes_r     <= bytes_nxt;
      plen_r      <= plen_nxt;
      held_r      <= held_nxt;
      disc_r      <= disc_nxt;
      head_len_r  <= head_len_nxt;
      head_load_r <= head_load_nxt;
      out_valid_r <= out_valid_nxt;
      iss_left_r  <= iss_left_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rem_r       <= rem_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_bank_r   <= rd_bank_nxt;
    end
  end

  // Result word, open store word and burst length.
  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_q_r <= out_q_nxt;
    end
    if (tail_we) begin
      tail_r <= (fill_sum >= 5'd8) ? spill_word : lo_word;
    end
    if (burst_we) begin
      burst_len_r <= head_len_r;
    end
  end

  // Result channel.
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_q_r.status;
  assign out_ch.out_word        = out_q_r.out_word;
  assign out_ch.out_count       = out_q_r.out_count;
  assign out_ch.out_last        = out_q_r.out_last;
  assign out_ch.message_length  = out_q_r.message_length;
  assign out_ch.messages_queued = out_q_r.messages_queued;
  assign out_ch.bytes_queued    = out_q_r.bytes_queued;

  // Bank steering: the packed word and its spill always land in opposite banks.
  always_comb begin
    b0_we    = (lo_we && !widx[0]) || (sp_we && widx[0]);
    b1_we    = (lo_we && widx[0]) || (sp_we && !widx[0]);
    b0_waddr = widx[0] ? widx_p1[WORD_AW-1:1] : widx[WORD_AW-1:1];
    b1_waddr = widx[0] ? widx[WORD_AW-1:1] : widx_p1[WORD_AW-1:1];
    b0_wdata = widx[0] ? spill_word : lo_word;
    b1_wdata = widx[0] ? lo_word : spill_word;
    b0_re    = rd_issue && !rd_idx_r[0];
    b1_re    = rd_issue && rd_idx_r[0];
  end

  // Even word bank.
  mpf_ram #(.WIDTH(DATA_W), .DEPTH(BANK_WORDS)) u_bank0 (
    .clk   (clk),
    .we    (b0_we),
    .waddr (b0_waddr),
    .wdata (b0_wdata),
    .re    (b0_re),
    .raddr (rd_idx_r[WORD_AW-1:1]),
    .rdata (b0_rdata)
  );

  // Odd word bank.
  mpf_ram #(.WIDTH(DATA_W), .DEPTH(BANK_WORDS)) u_bank1 (
    .clk   (clk),
    .we    (b1_we),
    .waddr (b1_waddr),
    .wdata (b1_wdata),
    .re    (b1_re),
    .raddr (rd_idx_r[WORD_AW-1:1]),
    .rdata (b1_rdata)
  );

  // Length descriptors; read at the slot after the one being freed.
  mpf_ram #(.WIDTH(LEN_W), .DEPTH(MESSAGE_SLOTS)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (swp_r),
    .wdata (LEN_W'(newlen)),
    .re    (slot_re),
    .raddr (srp_r + SLOT_AW'(1)),
    .rdata (slot_rdata)
  );

  // Checks on the queue bookkeeping and the burst pipeline.
  `MPF_ASSERT_IMP(a_empty_totals, clk, rst_n, cnt_r == '0, bytes_r == '0 && held_r == '0)
  `MPF_ASSERT_IMP(a_pend_kept, clk, rst_n, rd_pend_r && !ld_out, !rd_issue)
  `MPF_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_valid_r && !out_ch.ready, !ld_out)
  `MPF_ASSERT_IMP(a_burst_blocks, clk, rst_n, state_r == ST_POP || head_load_r, !in_acc)

endmodule

`default_nettype wire
